@@ src/csv_quoted_field_splitter_assert.svh @@
// ----------------------------------------------------------------------------
// csv_quoted_field_splitter assertion macros
// Shared concurrent assertion forms used by the splitter RTL.
// ----------------------------------------------------------------------------
`ifndef CSV_QUOTED_FIELD_SPLITTER_ASSERT_SVH
`define CSV_QUOTED_FIELD_SPLITTER_ASSERT_SVH

// same-cycle implication
`define CSVQS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSVQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/csvqs_pkg.sv @@
// ----------------------------------------------------------------------------
// csvqs_pkg
// Types and constants shared by the CSV quoted field splitter.
// ----------------------------------------------------------------------------
package csvqs_pkg;

   localparam logic [7:0]  QUOTE_BYTE          = 8'h22;
   localparam logic [7:0]  COMMA_BYTE          = 8'h2C;
   localparam int          MAX_COLUMNS_DEFAULT = 32;
   localparam int          CSR_WIDTH           = 32;
   localparam logic [31:0] CSR_RESET           = 32'd3;
   localparam int          QUEUE_DEPTH         = 2;
   localparam int          COL_INDEX_WIDTH     = 6;
   localparam int          COL_EXT_WIDTH       = 7;
   localparam int          CSR_INDEX_WIDTH     = 5;

   typedef enum logic [1:0] {
      MODE_PLAIN   = 2'd0,
      MODE_QUOTED  = 2'd1,
      MODE_PENDING = 2'd2
   } quote_mode_type;

   typedef struct packed {
      logic [7:0]                 out_byte;
      logic                       has_byte;
      logic [COL_INDEX_WIDTH-1:0] column_index;
      logic                       field_end;
      logic                       row_end;
   } rsp_item_type;

   typedef struct packed {
      logic full;
   } queue_status_type;

endpackage

@@ src/csvqs_front.sv @@
// ----------------------------------------------------------------------------
// csvqs_front
// Classifies each row byte, tracks quote mode and column, builds result beats.
// ----------------------------------------------------------------------------
`include "csv_quoted_field_splitter_assert.svh"

module csvqs_front #(
   parameter int MAX_COLUMNS = csvqs_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [31:0]              csr_column_select,
   input  logic                     req_valid,
   input  logic [7:0]               req_in_byte,
   input  logic                     req_row_last,
   input  csvqs_pkg::queue_status_type q_status,
   output logic                     req_ready,
   output logic                     push,
   output csvqs_pkg::rsp_item_type  push_item
);
   import csvqs_pkg::*;

   localparam int ColW = $clog2(MAX_COLUMNS + 1);

   logic [CSR_WIDTH-1:0] csr_ff;
   quote_mode_type       mode_ff, mode_in;
   logic [ColW-1:0]      col_ff, col_in;
   logic [COL_EXT_WIDTH-1:0] col_ext;
   logic accept, sel, content, separator, plain, has, fend;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign col_ext   = COL_EXT_WIDTH'(col_ff);

   always_comb begin
      sel = (col_ext < COL_EXT_WIDTH'(MAX_COLUMNS)) &&
            (col_ext < COL_EXT_WIDTH'(CSR_WIDTH)) &&
            csr_ff[col_ext[CSR_INDEX_WIDTH-1:0]];
      content   = 1'b0;
      separator = 1'b0;
      plain     = 1'b0;
      mode_in   = mode_ff;
      unique case (mode_ff)
         MODE_QUOTED: begin
            if (req_in_byte == QUOTE_BYTE) mode_in = MODE_PENDING;
            else content = 1'b1;
         end
         MODE_PENDING: begin
            if (req_in_byte == QUOTE_BYTE) begin
               content = 1'b1;
               mode_in = MODE_QUOTED;
            end else begin
               mode_in = MODE_PLAIN;
               plain   = 1'b1;
            end
         end
         default: plain = 1'b1;
      endcase
      if (plain) begin
         priority if (req_in_byte == QUOTE_BYTE) mode_in = MODE_QUOTED;
         else if (req_in_byte == COMMA_BYTE) separator = 1'b1;
         else content = 1'b1;
      end
      has  = content && sel;
      fend = (separator || req_row_last) && sel;
      col_in = col_ff;
      if (separator && (col_ff < ColW'(MAX_COLUMNS))) col_in = col_ff + 1'b1;
      if (req_row_last) begin
         mode_in = MODE_PLAIN;
         col_in  = '0;
      end
      push = accept && (has || fend || req_row_last);
      push_item.out_byte     = has ? req_in_byte : 8'd0;
      push_item.has_byte     = has;
      push_item.column_index = (col_ext > COL_EXT_WIDTH'(63)) ?
                               COL_INDEX_WIDTH'(63) : col_ext[COL_INDEX_WIDTH-1:0];
      push_item.field_end    = fend;
      push_item.row_end      = req_row_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff  <= CSR_RESET;
         mode_ff <= MODE_PLAIN;
         col_ff  <= '0;
      end else begin
         if (csr_valid) csr_ff <= csr_column_select;
         if (accept) begin
            mode_ff <= mode_in;
            col_ff  <= col_in;
         end
      end
   end

   `CSVQS_ASSERT_NEXT(a_row_end_clears, clock, reset, accept && req_row_last, (mode_ff == MODE_PLAIN) && (col_ff == '0), "state not cleared after row end")
   `CSVQS_ASSERT_IMPL(a_col_bound, clock, reset, 1'b1, col_ff <= ColW'(MAX_COLUMNS), "column counter past saturation")
   `CSVQS_ASSERT_IMPL(a_last_pushes, clock, reset, accept && req_row_last, push, "row end beat not queued")

endmodule

@@ src/csvqs_queue.sv @@
// ----------------------------------------------------------------------------
// csvqs_queue
// Short result queue between the classifier and the response channel.
// ----------------------------------------------------------------------------
`include "csv_quoted_field_splitter_assert.svh"

module csvqs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  csvqs_pkg::rsp_item_type    push_item,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output csvqs_pkg::rsp_item_type    rsp_item,
   output csvqs_pkg::queue_status_type q_status
);
   import csvqs_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   rsp_item_type    mem [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            pop;

   assign rsp_valid     = (count_ff != '0);
   assign rsp_item      = mem[rd_ptr_ff];
   assign pop           = rsp_valid && rsp_ready;
   assign q_status.full = (count_ff == CntW'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   `CSVQS_ASSERT_IMPL(a_no_overflow, clock, reset, q_status.full, !push, "push into full queue")
   `CSVQS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(QUEUE_DEPTH), "queue count out of range")
   `CSVQS_ASSERT_IMPL(a_empty_ptrs, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "pointers diverge while empty")

endmodule

@@ src/csv_quoted_field_splitter.sv @@
// ----------------------------------------------------------------------------
// csv_quoted_field_splitter
// Splits one CSV row per stream into fields, honoring double-quote escaping.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one row byte per beat, req_row_last on the row's final byte.
//   rsp_*  : zero or one result beat per request beat: a selected content
//            byte, a field end, and/or the row end.
//   csr_*  : column_select write channel, always ready; write while idle.
// Throughput: one byte per cycle while the queue is not full, limited by the single quote/column state
//   update in the classifier.
// A result is registered into the queue when its byte is taken; rsp_* show the queue head.
// A two-beat queue separates classifier and output, so req_ready stays
//   high while one result waits; it drops only when both slots hold beats.
// Reset: quote mode plain, column 0, column_select = 3, queue empty.
// Receiver stall: results hold in the queue and the input stalls once full;
//   nothing is dropped.
// ----------------------------------------------------------------------------
module csv_quoted_field_splitter #(
   parameter int MAX_COLUMNS = csvqs_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_column_select,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_row_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_has_byte,
   output logic [5:0]  rsp_column_index,
   output logic        rsp_field_end,
   output logic        rsp_row_end
);
   import csvqs_pkg::*;

   logic             push;
   rsp_item_type     push_item, rsp_item;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   csvqs_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_column_select (csr_column_select),
      .req_valid         (req_valid),
      .req_in_byte       (req_in_byte),
      .req_row_last      (req_row_last),
      .q_status          (q_status),
      .req_ready         (req_ready),
      .push              (push),
      .push_item         (push_item)
   );

   csvqs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .q_status  (q_status)
   );

   assign rsp_out_byte     = rsp_item.out_byte;
   assign rsp_has_byte     = rsp_item.has_byte;
   assign rsp_column_index = rsp_item.column_index;
   assign rsp_field_end    = rsp_item.field_end;
   assign rsp_row_end      = rsp_item.row_end;

endmodule

@@ verif/csv_quoted_field_splitter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_quoted_field_splitter_tb
// Drives CSV rows byte by byte through the splitter under random source and
// sink idling, predicts every result beat from the quote and column state,
// and compares each beat field by field in order. Runs a directed set of
// quoting corner cases, then random rows under several column masks.
// ----------------------------------------------------------------------------
module csv_quoted_field_splitter_tb;
   import csvqs_pkg::*;

   localparam int MAX_COLS     = MAX_COLUMNS_DEFAULT;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASE_ITEMS  = 300;
   localparam int NUM_PHASES   = 6;
   localparam int TAIL_CYCLES  = 4;
   localparam int REPORT_LIMIT = 10;

   class csv_row_scoreboard;
      logic [31:0]    select_mask;
      quote_mode_type mode;
      int             column;
      rsp_item_type   expected_beats[$];
      int             error_count;

      function new();
         select_mask = CSR_RESET;
         mode        = MODE_PLAIN;
         column      = 0;
         error_count = 0;
      endfunction

      function void set_select(logic [31:0] mask);
         select_mask = mask;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // accepted request beat
      function void take_byte(logic [7:0] b, logic last);
         int           col;
         bit           sel;
         bit           content;
         bit           separator;
         bit           plain;
         bit           has;
         bit           fend;
         rsp_item_type beat;
         col       = column;
         sel       = (col < MAX_COLS) && select_mask[col];
         content   = 0;
         separator = 0;
         plain     = 0;
         case (mode)
            MODE_QUOTED: begin
               if (b == QUOTE_BYTE) mode = MODE_PENDING;
               else content = 1;
            end
            MODE_PENDING: begin
               if (b == QUOTE_BYTE) begin
                  content = 1;
                  mode    = MODE_QUOTED;
               end else begin
                  mode  = MODE_PLAIN;
                  plain = 1;
               end
            end
            default: plain = 1;
         endcase
         if (plain) begin
            if (b == QUOTE_BYTE) mode = MODE_QUOTED;
            else if (b == COMMA_BYTE) separator = 1;
            else content = 1;
         end
         has  = content && sel;
         fend = 0;
         if (separator) begin
            fend = sel;
            if (column < MAX_COLS) column++;
         end
         if (last && !separator) fend = sel;
         if (last) begin
            mode   = MODE_PLAIN;
            column = 0;
         end
         if (has || fend || last) begin
            beat.out_byte     = has ? b : 8'h00;
            beat.has_byte     = has;
            beat.column_index = (col > 63) ? 6'd63 : col[5:0];
            beat.field_end    = fend;
            beat.row_end      = last;
            expected_beats.insert(expected_beats.size(), beat);
         end
      endfunction

      // accepted result beat
      function void check_beat(rsp_item_type got);
         rsp_item_type want;
         if (expected_beats.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result beat: %p", got);
            return;
         end
         want = expected_beats.pop_front();
         if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
             got.column_index !== want.column_index ||
             got.field_end !== want.field_end || got.row_end !== want.row_end) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("mismatch: out_byte %h/%h has_byte %b/%b ",
                        want.out_byte, got.out_byte, want.has_byte, got.has_byte,
                        "column_index %0d/%0d field_end %b/%b ",
                        want.column_index, got.column_index, want.field_end,
                        got.field_end,
                        "row_end %b/%b (expected/actual)",
                        want.row_end, got.row_end);
         end
      endfunction
   endclass

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        csr_valid         = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_column_select = '0;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte       = '0;
   logic        req_row_last      = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_has_byte;
   logic [5:0]  rsp_column_index;
   logic        rsp_field_end;
   logic        rsp_row_end;

   csv_quoted_field_splitter DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_column_select(csr_column_select),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_row_last     (req_row_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_column_index (rsp_column_index),
      .rsp_field_end    (rsp_field_end),
      .rsp_row_end      (rsp_row_end)
   );

   csv_row_scoreboard sb = new();
   logic [7:0]        row_text[$];
   bit                req_burst = 0;
   bit                rsp_burst = 0;
   int                cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("csv_quoted_field_splitter_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.out_byte     = rsp_out_byte;
         got.has_byte     = rsp_has_byte;
         got.column_index = rsp_column_index;
         got.field_end    = rsp_field_end;
         got.row_end      = rsp_row_end;
         sb.check_beat(got);
      end
   end

   // sink: random stall before each result beat
   initial begin
      int gap;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic void add_char(input logic [7:0] c);
      row_text.insert(row_text.size(), c);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_byte  <= b;
      req_row_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_byte(b, last);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic send_row();
      if (row_text.size() == 0) add_char("z");
      for (int i = 0; i < row_text.size(); i++)
         send_byte(row_text[i], i == row_text.size() - 1);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_select(input logic [31:0] mask);
      csr_valid         <= 1'b1;
      csr_column_select <= mask;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_select(mask);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == QUOTE_BYTE || c == COMMA_BYTE);
      return c;
   endfunction

   function automatic void build_row(int nfields, int max_len);
      int len;
      row_text.delete();
      for (int f = 0; f < nfields; f++) begin
         if (f != 0) add_char(COMMA_BYTE);
         len = $urandom_range(0, max_len);
         if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < len; i++) add_char(plain_char());
         end else begin
            add_char(QUOTE_BYTE);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 5))
                  0: add_char(COMMA_BYTE);
                  1: begin
                     add_char(QUOTE_BYTE);
                     add_char(QUOTE_BYTE);
                  end
                  default: add_char(plain_char());
               endcase
            end
            // last field sometimes left unterminated
            if (f != nfields - 1 || $urandom_range(0, 7) != 0)
               add_char(QUOTE_BYTE);
            if ($urandom_range(0, 7) == 0) add_char(plain_char());
         end
      end
   endfunction

   function automatic void build_noise();
      int len;
      row_text.delete();
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 3))
            0: add_char(QUOTE_BYTE);
            1: add_char(COMMA_BYTE);
            default: add_char(8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   initial begin
      logic [31:0] masks[NUM_PHASES];
      int          phase_items;
      masks[0] = 32'hFFFF_FFFF;
      masks[1] = 32'h0000_0000;
      masks[2] = $urandom();
      masks[3] = 32'h8000_0001;
      masks[4] = 32'h0000_00F5;
      masks[5] = CSR_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset mask
      send_text("\"a,\"\"b\"x,c,d");
      send_text("\"\"");
      send_text("e,");
      send_text("\"f");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text("g\"h");

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_select(masks[p]);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            req_burst = ($urandom_range(0, 3) == 0);
            rsp_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) build_noise();
            else if ($urandom_range(0, 9) == 0) build_row($urandom_range(30, 40), 1);
            else build_row($urandom_range(1, 6), 5);
            send_row();
            phase_items += row_text.size();
         end
      end

      wait_idle();
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("csv_quoted_field_splitter_tb passed");
      else
         $display("csv_quoted_field_splitter_tb failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/csvqs_pkg.sv
src/csvqs_front.sv
src/csvqs_queue.sv
src/csv_quoted_field_splitter.sv
verif/csv_quoted_field_splitter_tb.sv
